// ===== rtl/tdpc_pkg.sv =====
// Shared types, constants and helper functions of the two-dimensional parity classifier.
package tdpc_pkg;

	localparam int ROW_W     = 20;
	localparam int COUNT_W   = 5;
	localparam int TOTAL_W   = 6;
	localparam int DEF_WIDTH = 20;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		VERDICT_CORRECT      = 2'd0,
		VERDICT_REPAIRABLE   = 2'd1,
		VERDICT_UNREPAIRABLE = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [COUNT_W-1:0] row_errors;
		logic [COUNT_W-1:0] column_errors;
		logic [TOTAL_W-1:0] total_errors;
		verdict_t           verdict;
	} result_t;

	// Columns at or above the image width carry no pixels.
	function automatic logic [ROW_W-1:0] col_mask(input int width);
		logic [ROW_W-1:0] m;
		m = '0;
		for (int j = 0; j < ROW_W; j++) begin
			m[j] = (j < width);
		end
		return m;
	endfunction

	function automatic logic [COUNT_W-1:0] ones_count(input logic [ROW_W-1:0] v);
		logic [COUNT_W-1:0] c;
		c = '0;
		for (int j = 0; j < ROW_W; j++) begin
			c = c + COUNT_W'(v[j]);
		end
		return c;
	endfunction

endpackage

// ===== rtl/tdpc_ifs.sv =====
// Valid/ready channel interfaces for image rows and classification results.
interface tdpc_row_if;
	logic                      valid;
	logic                      ready;
	logic [tdpc_pkg::ROW_W-1:0] row_bits;
	logic                      row_parity;

	modport source (output valid, output row_bits, output row_parity, input ready);
	modport sink (input valid, input row_bits, input row_parity, output ready);
endinterface

interface tdpc_result_if;
	logic                        valid;
	logic                        ready;
	logic [tdpc_pkg::COUNT_W-1:0] row_errors;
	logic [tdpc_pkg::COUNT_W-1:0] column_errors;
	logic [tdpc_pkg::TOTAL_W-1:0] total_errors;
	logic [1:0]                  verdict;

	modport source (output valid, output row_errors, output column_errors,
		output total_errors, output verdict, input ready);
	modport sink (input valid, input row_errors, input column_errors,
		input total_errors, input verdict, output ready);
endinterface

// ===== rtl/tdpc_core.sv =====
// Per-image state (row counter, column parity accumulator, row mismatch count) and the combinational verdict.
module tdpc_core #(
	parameter int WIDTH = tdpc_pkg::DEF_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [tdpc_pkg::ROW_W-1:0] row_bits,
	input  logic                       row_parity,
	output logic                       parity_row,
	output tdpc_pkg::result_t          result
);

	localparam int IDX_W = $clog2(WIDTH + 1);
	localparam logic [tdpc_pkg::ROW_W-1:0] COL_MASK = tdpc_pkg::col_mask(WIDTH);

	logic [IDX_W-1:0]                 row_idx_q;
	logic [tdpc_pkg::ROW_W-1:0]       col_acc_q;
	logic [tdpc_pkg::COUNT_W-1:0]     row_err_q;
	logic [tdpc_pkg::ROW_W-1:0]       bits_m;
	logic                             mismatch;
	logic [tdpc_pkg::COUNT_W-1:0]     col_err;

	assign bits_m     = row_bits & COL_MASK;
	assign parity_row = (row_idx_q == IDX_W'(WIDTH));
	assign mismatch   = (^bits_m) != row_parity;
	assign col_err    = tdpc_pkg::ones_count(col_acc_q ^ bits_m);

	always_comb begin
		result.row_errors    = row_err_q;
		result.column_errors = col_err;
		// The row count saturates at 31 and at most 20 columns exist, so the sum stays below 64.
		result.total_errors  = tdpc_pkg::TOTAL_W'(row_err_q) + tdpc_pkg::TOTAL_W'(col_err);
		if (row_err_q == '0 && col_err == '0) begin
			result.verdict = tdpc_pkg::VERDICT_CORRECT;
		end else if (row_err_q <= tdpc_pkg::COUNT_W'(1) && col_err <= tdpc_pkg::COUNT_W'(1)) begin
			result.verdict = tdpc_pkg::VERDICT_REPAIRABLE;
		end else begin
			result.verdict = tdpc_pkg::VERDICT_UNREPAIRABLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q <= '0;
			col_acc_q <= '0;
			row_err_q <= '0;
		end else if (step) begin
			if (parity_row) begin
				row_idx_q <= '0;
				col_acc_q <= '0;
				row_err_q <= '0;
			end else begin
				row_idx_q <= row_idx_q + IDX_W'(1);
				col_acc_q <= col_acc_q ^ bits_m;
				if (mismatch && row_err_q != tdpc_pkg::COUNT_MAX) begin
					row_err_q <= row_err_q + tdpc_pkg::COUNT_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/two_dim_parity_classifier.sv =====
// Top level: input register, parity state and result register of the image classifier.
// Flow: a parity row's result is captured in the output register once that register is free.
// Throughput: one row per cycle; the input stalls only while a parity row waits for an
// earlier result that is still held in the output register.
// Reset: arst_n clears the row counter, the column parity and the error count at once,
// and empties the input and output registers.
module two_dim_parity_classifier #(
	parameter int WIDTH = tdpc_pkg::DEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	tdpc_row_if.sink    rows,
	tdpc_result_if.source results
);

	logic                       valid_s1;
	logic [tdpc_pkg::ROW_W-1:0] bits_s1;
	logic                       parity_s1;
	logic                       parity_row;
	logic                       step;
	logic                       out_free;
	logic                       out_valid_q;
	tdpc_pkg::result_t          result;
	tdpc_pkg::result_t          result_q;

	assign out_free   = !out_valid_q || results.ready;
	assign step       = valid_s1 && (!parity_row || out_free);
	assign rows.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rows.ready) begin
			valid_s1 <= rows.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rows.ready && rows.valid) begin
			bits_s1   <= rows.row_bits;
			parity_s1 <= rows.row_parity;
		end
	end

	tdpc_core #(
		.WIDTH(WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.row_bits   (bits_s1),
		.row_parity (parity_s1),
		.parity_row (parity_row),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && parity_row) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && parity_row) begin
			result_q <= result;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.row_errors    = result_q.row_errors;
	assign results.column_errors = result_q.column_errors;
	assign results.total_errors  = result_q.total_errors;
	assign results.verdict       = result_q.verdict;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the two-dimensional parity classifier: directed and random images.
module tb;

	localparam int IMG_W       = tdpc_pkg::DEF_WIDTH;
	localparam int RAND_IMAGES = 66;
	localparam int PAUSE_IMAGE = 30;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_LEN    = 150;
	localparam int QUIET_LIMIT = 3000;
	localparam int TOTAL_CAP   = (1 << tdpc_pkg::TOTAL_W) - 1;

	typedef struct {
		logic [tdpc_pkg::ROW_W-1:0] fill;
		logic [IMG_W-1:0]           row_flips;
		logic [tdpc_pkg::ROW_W-1:0] col_flips;
		tdpc_pkg::result_t          report;
	} image_case_t;

	// Fixed images: all ones and clean, one row and one column bad, everything bad.
	image_case_t image_cases [3] = '{
		'{20'hFFFFF, '0, '0, '{row_errors: 5'd0, column_errors: 5'd0,
			total_errors: 6'd0, verdict: tdpc_pkg::VERDICT_CORRECT}},
		'{20'hAAAAA, 20'h00080, 20'h02000, '{row_errors: 5'd1, column_errors: 5'd1,
			total_errors: 6'd2, verdict: tdpc_pkg::VERDICT_REPAIRABLE}},
		'{20'h00000, '1, '1, '{row_errors: 5'd20, column_errors: 5'd20,
			total_errors: 6'd40, verdict: tdpc_pkg::VERDICT_UNREPAIRABLE}}
	};

	logic clk;
	logic arst_n;

	tdpc_row_if    row_ch ();
	tdpc_result_if res_ch ();

	two_dim_parity_classifier #(.WIDTH(IMG_W)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rows    (row_ch),
		.results (res_ch)
	);

	// Shadow state of the image being received.
	int                         img_rows;
	logic [tdpc_pkg::ROW_W-1:0] col_acc;
	int                         row_mism;

	tdpc_pkg::result_t expected_reports [$];
	int                rows_taken;
	int                quiet_cycles;
	int                mismatches;
	int                hold_left;
	bit                hold_done;
	tdpc_pkg::result_t want;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int idle_phase();
		return (rows_taken / 126) % 4;
	endfunction

	function automatic int sender_idle_pct();
		case (idle_phase())
			1: return 75;
			3: return 28;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_phase())
			2: return 75;
			3: return 28;
			default: return 0;
		endcase
	endfunction

	function automatic logic [tdpc_pkg::ROW_W-1:0] random_row();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return tdpc_pkg::ROW_W'($urandom);
		endcase
	endfunction

	// Advances the shadow state by one row; returns 1 on the parity row with its report.
	function automatic bit classify_row(input logic [tdpc_pkg::ROW_W-1:0] bits_in,
			input logic par, output tdpc_pkg::result_t report);
		logic [tdpc_pkg::ROW_W-1:0] mask;
		logic [tdpc_pkg::ROW_W-1:0] bits;
		int                         col_mism;
		int                         total;
		for (int j = 0; j < tdpc_pkg::ROW_W; j++) begin
			mask[j] = (j < IMG_W);
		end
		bits = bits_in & mask;
		report = '0;
		if (img_rows < IMG_W) begin
			if ((^bits) != par && row_mism < int'(tdpc_pkg::COUNT_MAX)) begin
				row_mism++;
			end
			col_acc = col_acc ^ bits;
			img_rows++;
			return 1'b0;
		end
		col_mism = $countones((col_acc ^ bits) & mask);
		if (col_mism > int'(tdpc_pkg::COUNT_MAX)) begin
			col_mism = int'(tdpc_pkg::COUNT_MAX);
		end
		total = row_mism + col_mism;
		if (total > TOTAL_CAP) begin
			total = TOTAL_CAP;
		end
		report.row_errors    = tdpc_pkg::COUNT_W'(row_mism);
		report.column_errors = tdpc_pkg::COUNT_W'(col_mism);
		report.total_errors  = tdpc_pkg::TOTAL_W'(total);
		if (row_mism == 0 && col_mism == 0) begin
			report.verdict = tdpc_pkg::VERDICT_CORRECT;
		end else if (row_mism <= 1 && col_mism <= 1) begin
			report.verdict = tdpc_pkg::VERDICT_REPAIRABLE;
		end else begin
			report.verdict = tdpc_pkg::VERDICT_UNREPAIRABLE;
		end
		img_rows = 0;
		col_acc  = '0;
		row_mism = 0;
		return 1'b1;
	endfunction

	// Starts and ends at a falling edge; valid is left high for the caller to keep or drop.
	task automatic send_row(input logic [tdpc_pkg::ROW_W-1:0] bits, input logic par,
			input bit typed, input tdpc_pkg::result_t typed_report);
		tdpc_pkg::result_t predicted;
		bit                has_report;
		while ($urandom_range(0, 99) < sender_idle_pct()) begin
			row_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_ch.valid      <= 1'b1;
		row_ch.row_bits   <= bits;
		row_ch.row_parity <= par;
		@(posedge clk);
		while (!row_ch.ready) begin
			@(posedge clk);
		end
		has_report = classify_row(bits, par, predicted);
		if (has_report) begin
			expected_reports.push_back(typed ? typed_report : predicted);
		end
		@(negedge clk);
	endtask

	task automatic send_image(input bit use_fill, input logic [tdpc_pkg::ROW_W-1:0] fill,
			input logic [IMG_W-1:0] row_flips, input logic [tdpc_pkg::ROW_W-1:0] col_flips,
			input bit noisy, input bit typed, input tdpc_pkg::result_t typed_report);
		logic [tdpc_pkg::ROW_W-1:0] data;
		logic [tdpc_pkg::ROW_W-1:0] parity_row;
		logic                       par;
		parity_row = '0;
		for (int r = 0; r < IMG_W; r++) begin
			data = use_fill ? fill : random_row();
			par  = noisy ? 1'($urandom) : ((^data) ^ row_flips[r]);
			parity_row = parity_row ^ data;
			send_row(data, par, typed, typed_report);
		end
		// The row parity bit of the parity row carries no meaning, so it is random.
		send_row(parity_row ^ col_flips, 1'($urandom), typed, typed_report);
	endtask

	task automatic drain_reports();
		row_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_reports.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int                         kind;
		logic [IMG_W-1:0]           row_flips;
		logic [tdpc_pkg::ROW_W-1:0] col_flips;
		bit                         noisy;
		arst_n            = 1'b0;
		row_ch.valid      = 1'b0;
		row_ch.row_bits   = '0;
		row_ch.row_parity = 1'b0;
		res_ch.ready      = 1'b0;
		img_rows          = 0;
		col_acc           = '0;
		row_mism          = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (image_cases[i]) begin
			send_image(1'b1, image_cases[i].fill, image_cases[i].row_flips,
				image_cases[i].col_flips, 1'b0, 1'b1, image_cases[i].report);
		end

		for (int img = 0; img < RAND_IMAGES; img++) begin
			if (img == PAUSE_IMAGE) begin
				drain_reports();
			end
			row_flips = '0;
			col_flips = '0;
			noisy     = 1'b0;
			kind      = $urandom_range(0, 9);
			case (kind)
				4, 5: begin
					row_flips[$urandom_range(0, IMG_W-1)] = 1'($urandom);
					col_flips[$urandom_range(0, IMG_W-1)] = 1'($urandom);
				end
				6, 7: begin
					row_flips = IMG_W'($urandom & $urandom & $urandom);
					col_flips = tdpc_pkg::ROW_W'($urandom & $urandom & $urandom);
				end
				8: begin
					noisy     = 1'b1;
					col_flips = tdpc_pkg::ROW_W'($urandom);
				end
				9: begin
					row_flips = IMG_W'($urandom);
					col_flips = tdpc_pkg::ROW_W'($urandom);
				end
				default: ;
			endcase
			send_image(1'b0, '0, row_flips, col_flips, noisy, 1'b0, '0);
		end

		drain_reports();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Result side: random stalls, plus one long hold-off so the parity rows back up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!hold_done && rows_taken >= HOLD_AT) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_LEN;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (row_ch.valid && row_ch.ready) begin
				rows_taken <= rows_taken + 1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_reports.size() == 0) begin
					$error("report with no pending image: row_errors %0d column_errors %0d",
						res_ch.row_errors, res_ch.column_errors);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					if (res_ch.row_errors !== want.row_errors) begin
						$error("row_errors: expected %0d, got %0d",
							want.row_errors, res_ch.row_errors);
						mismatches++;
					end
					if (res_ch.column_errors !== want.column_errors) begin
						$error("column_errors: expected %0d, got %0d",
							want.column_errors, res_ch.column_errors);
						mismatches++;
					end
					if (res_ch.total_errors !== want.total_errors) begin
						$error("total_errors: expected %0d, got %0d",
							want.total_errors, res_ch.total_errors);
						mismatches++;
					end
					if (res_ch.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, res_ch.verdict);
						mismatches++;
					end
				end
			end
			if ((row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
